>>> src/olt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and codes for the ordered list table: request codes, status
// codes, cell operation codes and the control bundle that drives the cells.
// ----------------------------------------------------------------------------
package olt_pkg;

    // built depth and field widths
    localparam int DEF_MAX_ENTRIES = 32;
    localparam int DATA_W          = 32;
    localparam int CAP_W           = 6;
    localparam int POS_W           = 6;
    localparam int REQ_W           = 3;
    localparam int STAT_W          = 2;
    localparam int CNT_OUT_W       = 6;

    // capacity register reset value
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // register index of the capacity register
    localparam logic REG_CAPACITY = 1'b0;

    // request codes
    localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SORT    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    // cell operations
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op OP_HOLD = 2'd0;
    localparam t_cell_op OP_INS  = 2'd1;
    localparam t_cell_op OP_DEL  = 2'd2;
    localparam t_cell_op OP_SWAP = 2'd3;

    // control bundle broadcast to every cell
    typedef struct packed {
        t_cell_op op;
        logic     force_swap;
        logic     phase;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> src/olt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_cell
// One entry of the list. Loads a new value, takes its left or right
// neighbor for insert/delete shifts, or does one odd-even transposition step.
// ----------------------------------------------------------------------------
module olt_cell import olt_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int IDX         = 0
) (
    input  wire                                 i_clk,
    input  t_cell_ctl                           i_ctl,
    input  wire [$clog2(MAX_ENTRIES+1)-1:0]     i_tgt,
    input  wire [$clog2(MAX_ENTRIES+1)-1:0]     i_count,
    input  wire [DATA_W-1:0]                    i_value,
    input  wire [DATA_W-1:0]                    i_left,
    input  wire [DATA_W-1:0]                    i_right,
    output logic [DATA_W-1:0]                   o_entry
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_N  = CW'(IDX + 1);
    localparam logic          PAR    = 1'(IDX % 2);
    localparam logic          HAS_LT = (IDX > 0);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    logic              w_lower;
    logic              w_upper;

    // role in the current transposition phase
    assign w_lower = (PAR == i_ctl.phase) && (IDX_N < i_count);
    assign w_upper = HAS_LT && (PAR != i_ctl.phase) && (IDX_C < i_count);

    // next entry value
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_INS: begin
                if (IDX_C == i_tgt) begin
                    n_entry = i_value;
                end else if (IDX_C > i_tgt) begin
                    n_entry = i_left;
                end
            end
            OP_DEL: begin
                if (IDX_C >= i_tgt) begin
                    n_entry = i_right;
                end
            end
            OP_SWAP: begin
                if (w_lower) begin
                    if (i_ctl.force_swap || ($signed(r_entry) > $signed(i_right))) begin
                        n_entry = i_right;
                    end
                end else if (w_upper) begin
                    if (i_ctl.force_swap || ($signed(i_left) > $signed(r_entry))) begin
                        n_entry = i_left;
                    end
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

>>> src/olt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_ctrl
// Request decode, entry count, capacity register, transposition sequencer
// and result registers for the ordered list table.
// ----------------------------------------------------------------------------
module olt_ctrl import olt_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire [REQ_W-1:0]                     i_req_type,
    input  wire [POS_W-1:0]                     i_position,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [2:0]                           paddr,
    input  wire [31:0]                          pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire [DATA_W-1:0]                    i_rd_data,
    output t_cell_ctl                           o_ctl,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]    o_tgt,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]    o_cell_cnt,
    output logic                                o_done,
    output logic [STAT_W-1:0]                   o_status,
    output logic [DATA_W-1:0]                   o_data,
    output logic [CNT_OUT_W-1:0]                o_count,
    output logic                                o_full_res,
    output logic                                o_empty_res
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [PW-1:0] MAX_P = PW'(MAX_ENTRIES);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SORT = 1'b1;

    logic              r_state,  n_state;
    logic [CW-1:0]     r_count,  n_count;
    logic [CW-1:0]     r_round,  n_round;
    logic              r_force,  n_force;
    logic [CAP_W-1:0]  r_cap;
    logic              r_done,   n_done;
    logic [STAT_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_data,   n_data;
    logic              r_full,   r_empty;

    logic [PW-1:0]     w_cap_eff;
    logic [PW-1:0]     w_cnt_p;
    logic [PW-1:0]     w_pos_p;
    logic [PW-1:0]     w_pos_m1;
    logic              w_full_now;
    logic              w_accept;
    logic              w_cfg_wr;
    logic [PW-1:0]     w_ncnt_p;

    // effective capacity: zero acts as one, clipped at the built depth
    always_comb begin
        if (r_cap == '0) begin
            w_cap_eff = PW'(1);
        end else if (PW'(r_cap) > MAX_P) begin
            w_cap_eff = MAX_P;
        end else begin
            w_cap_eff = PW'(r_cap);
        end
    end

    assign w_cnt_p    = PW'(r_count);
    assign w_pos_p    = PW'(i_position);
    assign w_pos_m1   = w_pos_p - PW'(1);
    assign w_full_now = (w_cnt_p >= w_cap_eff);
    assign w_accept   = start && !busy;
    assign busy       = (r_state == S_SORT);

    // request decode and sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_round    = r_round;
        n_force    = r_force;
        n_done     = 1'b0;
        n_status   = r_status;
        n_data     = r_data;
        o_ctl.op         = OP_HOLD;
        o_ctl.force_swap = r_force;
        o_ctl.phase      = r_round[0];
        o_tgt      = w_pos_m1[CW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_data   = '0;
                    case (i_req_type)
                        REQ_APPEND: begin
                            o_tgt = r_count;
                            if (w_full_now) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ctl.op = OP_INS;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        REQ_INSERT: begin
                            if (w_full_now) begin
                                n_status = ST_FULL;
                            end else if (i_position == '0 || w_pos_m1 > w_cnt_p) begin
                                n_status = ST_BADPOS;
                            end else begin
                                o_ctl.op = OP_INS;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        REQ_DELETE, REQ_READ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (i_position == '0 || w_pos_p > w_cnt_p) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_data = i_rd_data;
                                if (i_req_type == REQ_DELETE) begin
                                    o_ctl.op = OP_DEL;
                                    n_count  = r_count - CW'(1);
                                end
                            end
                        end
                        REQ_REVERSE, REQ_SORT: begin
                            if (r_count == '0 && i_req_type == REQ_SORT) begin
                                n_status = ST_EMPTY;
                            end else if (r_count > CW'(1)) begin
                                n_done  = 1'b0;
                                n_state = S_SORT;
                                n_round = '0;
                                n_force = (i_req_type == REQ_REVERSE);
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SORT: begin
                // one odd-even transposition round per cycle
                o_ctl.op = OP_SWAP;
                n_round  = r_round + CW'(1);
                if (r_round == r_count - CW'(1)) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_data   = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_ncnt_p = PW'(n_count);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_round <= '0;
            r_force <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_round <= n_round;
            r_force <= n_force;
            r_done  <= n_done;
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_full   <= (w_ncnt_p >= w_cap_eff);
        r_empty  <= (n_count == '0);
    end

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (w_cfg_wr) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, r_cap} : '0;

    // outputs
    assign o_cell_cnt  = r_count;
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_count     = w_cnt_p[CNT_OUT_W-1:0];
    assign o_full_res  = r_full;
    assign o_empty_res = r_empty;

endmodule
`default_nettype wire

>>> src/ordered_list_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_table
// Bounded list of signed 32-bit values held in a row of cells: append,
// insert, delete, reverse, sort ascending and read, each with one result.
// ----------------------------------------------------------------------------
// append, insert, delete, read and unused codes give o_done in the cycle after
//   start is taken; busy stays low, so a request may follow each cycle
// reverse and sort on n >= 2 entries run n odd-even transposition rounds, one
//   per cycle across the cell row, busy high; o_done registered from the last round
// synchronous active-low reset clears the count and sequencer, capacity to 32
// results show for one cycle and cannot be stalled; entries are not reset
module ordered_list_table import olt_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire [REQ_W-1:0]       i_req_type,
    input  wire [POS_W-1:0]       i_position,
    input  wire signed [DATA_W-1:0] i_value,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire [2:0]             paddr,
    input  wire [31:0]            pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic                  o_done,
    output logic [STAT_W-1:0]     o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic [CNT_OUT_W-1:0]  o_count,
    output logic                  o_full_res,
    output logic                  o_empty_res
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);

    t_cell_ctl         w_ctl;
    logic [CW-1:0]     w_tgt;
    logic [CW-1:0]     w_cell_cnt;
    logic [DATA_W-1:0] w_ent [MAX_ENTRIES];
    logic [DATA_W-1:0] w_rd_data;
    logic [DATA_W-1:0] w_data;

    // request control
    olt_ctrl #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_rd_data   (w_rd_data),
        .o_ctl       (w_ctl),
        .o_tgt       (w_tgt),
        .o_cell_cnt  (w_cell_cnt),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_data      (w_data),
        .o_count     (o_count),
        .o_full_res  (o_full_res),
        .o_empty_res (o_empty_res)
    );

    assign o_data = $signed(w_data);

    // row of cells, each linked to its neighbors; the end cells see zero outside
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_ent[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_ent[g+1];
        end

        olt_cell #(
            .MAX_ENTRIES(MAX_ENTRIES),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_tgt   (w_tgt),
            .i_count (w_cell_cnt),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_ent[g])
        );
    end

    // read port for read and delete
    assign w_rd_data = w_ent[w_tgt[IW-1:0]];

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ordered list table. A short stimulus table
// covers empty and bad position errors, extreme values and every request
// code. Random requests then follow under several capacity settings. Each
// request is scored against an in-bench list predictor or its table row,
// and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
    import olt_pkg::*;

    localparam int DEPTH          = DEF_MAX_ENTRIES;
    localparam int ITEMS_PER_PASS = 88;
    localparam int NUM_PASSES     = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;

    // request codes the block treats as no-ops
    localparam logic [REQ_W-1:0] REQ_NOP6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_NOP7 = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
        logic [CNT_OUT_W-1:0]     count;
        logic                     full;
        logic                     empty;
    } t_list_result;

    typedef struct {
        logic [REQ_W-1:0]         req;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        bit                       typed;
        t_list_result             res;
    } t_stim_row;

    // clock and dut signals
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [REQ_W-1:0]         i_req_type = '0;
    logic [POS_W-1:0]         i_position = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [2:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    wire  [31:0]              prdata;
    wire                      pready;
    wire                      busy;
    wire                      o_done;
    wire  [STAT_W-1:0]        o_status;
    wire  signed [DATA_W-1:0] o_data;
    wire  [CNT_OUT_W-1:0]     o_count;
    wire                      o_full_res;
    wire                      o_empty_res;

    // predictor state
    logic signed [DATA_W-1:0] list_mem [DEPTH];
    int                       list_len = 0;
    logic [CAP_W-1:0]         cap_reg = CAP_RESET;

    t_list_result pending_results [$];
    t_stim_row    dir_rows [$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;

    ordered_list_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .i_value     (i_value),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_count     (o_count),
        .o_full_res  (o_full_res),
        .o_empty_res (o_empty_res)
    );

    // free-running clock
    always #5 i_clk = ~i_clk;

    // list predictor: applies one request and returns its result
    task automatic predict_list_request(
        input  logic [REQ_W-1:0]         req,
        input  logic [POS_W-1:0]         pos,
        input  logic signed [DATA_W-1:0] val,
        output t_list_result             res
    );
        int                       cap;
        int                       p;
        int                       i;
        int                       j;
        bit                       at_cap;
        logic signed [DATA_W-1:0] tmp;
        cap = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
        at_cap = list_len >= cap;
        p = int'(pos);
        res.status = ST_OK;
        res.data = '0;
        case (req)
            REQ_APPEND: begin
                if (at_cap) begin
                    res.status = ST_FULL;
                end else begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            REQ_INSERT: begin
                if (at_cap) begin
                    res.status = ST_FULL;
                end else if (p < 1 || p > list_len + 1) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p-1] = val;
                    list_len++;
                end
            end
            REQ_DELETE, REQ_READ: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p < 1 || p > list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.data = list_mem[p-1];
                    if (req == REQ_DELETE) begin
                        for (i = p; i < list_len; i++) list_mem[i-1] = list_mem[i];
                        list_len--;
                    end
                end
            end
            REQ_REVERSE: begin
                i = 0;
                j = list_len - 1;
                while (i < j) begin
                    tmp = list_mem[i];
                    list_mem[i] = list_mem[j];
                    list_mem[j] = tmp;
                    i++;
                    j--;
                end
            end
            REQ_SORT: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // insertion sort on signed values
                    for (i = 1; i < list_len; i++) begin
                        tmp = list_mem[i];
                        j = i - 1;
                        while (j >= 0 && list_mem[j] > tmp) begin
                            list_mem[j+1] = list_mem[j];
                            j--;
                        end
                        list_mem[j+1] = tmp;
                    end
                end
            end
            default: ;
        endcase
        res.count = CNT_OUT_W'(list_len);
        res.full = list_len >= cap;
        res.empty = list_len == 0;
    endtask

    // drive one request, wait for it to be taken, record its expected result
    task automatic issue_request(
        input logic [REQ_W-1:0]         req,
        input logic [POS_W-1:0]         pos,
        input logic signed [DATA_W-1:0] val,
        input bit                       typed,
        input t_list_result             typed_res
    );
        t_list_result res;
        start <= 1'b1;
        i_req_type <= req;
        i_position <= pos;
        i_value <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_list_request(req, pos, val, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // capacity write over the register port, only once the table is idle
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_CAPACITY);
        pwdata <= 32'(cap);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cap_reg = cap;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic add_row(
        input logic [REQ_W-1:0]         req,
        input logic [POS_W-1:0]         pos,
        input logic signed [DATA_W-1:0] val,
        input bit                       typed,
        input logic [STAT_W-1:0]        status,
        input logic signed [DATA_W-1:0] data,
        input logic [CNT_OUT_W-1:0]     count,
        input logic                     full,
        input logic                     empty
    );
        t_stim_row row;
        row.req = req;
        row.pos = pos;
        row.val = val;
        row.typed = typed;
        row.res.status = status;
        row.res.data = data;
        row.res.count = count;
        row.res.full = full;
        row.res.empty = empty;
        dir_rows.push_back(row);
    endtask

    // request mix: growing passes favor appends, draining passes favor deletes
    function automatic logic [REQ_W-1:0] pick_request(input bit drain);
        int r;
        r = $urandom_range(0, 99);
        if (drain) begin
            if (r < 12) return REQ_APPEND;
            if (r < 25) return REQ_INSERT;
            if (r < 62) return REQ_DELETE;
            if (r < 77) return REQ_READ;
            if (r < 85) return REQ_REVERSE;
            if (r < 93) return REQ_SORT;
        end else begin
            if (r < 30) return REQ_APPEND;
            if (r < 55) return REQ_INSERT;
            if (r < 72) return REQ_DELETE;
            if (r < 82) return REQ_READ;
            if (r < 88) return REQ_REVERSE;
            if (r < 94) return REQ_SORT;
        end
        return r[0] ? REQ_NOP7 : REQ_NOP6;
    endfunction

    // mostly legal positions, some anywhere in the field
    function automatic logic [POS_W-1:0] pick_position(input logic [REQ_W-1:0] req);
        int top;
        if ($urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, 63));
        top = (req == REQ_INSERT) ? list_len + 1 : list_len;
        if (top < 1) top = 1;
        return POS_W'($urandom_range(1, top));
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '0;
                    default: return -1;
                endcase
            end
            // narrow range so sorts see duplicates
            1: return $signed(32'($urandom_range(0, 15))) - 8;
            default: return $signed($urandom());
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request pending, status %0d data %0d",
                         $time, o_status, o_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    mismatch_count++;
                end
                if (o_data !== want.data) begin
                    $display("%0t: data expected %0d actual %0d", $time, want.data, o_data);
                    mismatch_count++;
                end
                if (o_count !== want.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, o_count);
                    mismatch_count++;
                end
                if (o_full_res !== want.full) begin
                    $display("%0t: full expected %0b actual %0b",
                             $time, want.full, o_full_res);
                    mismatch_count++;
                end
                if (o_empty_res !== want.empty) begin
                    $display("%0t: empty expected %0b actual %0b",
                             $time, want.empty, o_empty_res);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with neither a request nor a result taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        t_list_result    no_res;
        logic [CAP_W-1:0] pass_caps [NUM_PASSES];
        logic [REQ_W-1:0] req;
        int               burst_left;
        int               gap;

        no_res = '{default: '0};
        pass_caps = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd2, 6'd33, 6'd20,
                      CAP_W'($urandom_range(0, 63))};

        // error cases on an empty table, extremes, every request code
        add_row(REQ_READ,    6'd1,  32'sd0,  1, ST_EMPTY,  '0,      6'd0, 0, 1);
        add_row(REQ_DELETE,  6'd1,  32'sd0,  1, ST_EMPTY,  '0,      6'd0, 0, 1);
        add_row(REQ_SORT,    6'd0,  32'sd0,  1, ST_EMPTY,  '0,      6'd0, 0, 1);
        add_row(REQ_REVERSE, 6'd0,  32'sd0,  1, ST_OK,     '0,      6'd0, 0, 1);
        add_row(REQ_NOP6,    6'd63, -32'sd1, 1, ST_OK,     '0,      6'd0, 0, 1);
        add_row(REQ_NOP7,    6'd0,  32'sd0,  1, ST_OK,     '0,      6'd0, 0, 1);
        add_row(REQ_INSERT,  6'd0,  32'sd5,  1, ST_BADPOS, '0,      6'd0, 0, 1);
        add_row(REQ_INSERT,  6'd2,  32'sd5,  1, ST_BADPOS, '0,      6'd0, 0, 1);
        add_row(REQ_APPEND,  6'd0,  VAL_MAX, 1, ST_OK,     '0,      6'd1, 0, 0);
        add_row(REQ_INSERT,  6'd1,  VAL_MIN, 1, ST_OK,     '0,      6'd2, 0, 0);
        add_row(REQ_INSERT,  6'd3,  -32'sd1, 0, ST_OK,     '0,      6'd0, 0, 0);
        add_row(REQ_INSERT,  6'd63, 32'sd9,  1, ST_BADPOS, '0,      6'd3, 0, 0);
        add_row(REQ_READ,    6'd0,  32'sd0,  1, ST_BADPOS, '0,      6'd3, 0, 0);
        add_row(REQ_READ,    6'd4,  32'sd0,  1, ST_BADPOS, '0,      6'd3, 0, 0);
        add_row(REQ_READ,    6'd1,  32'sd0,  1, ST_OK,     VAL_MIN, 6'd3, 0, 0);
        add_row(REQ_READ,    6'd2,  32'sd0,  1, ST_OK,     VAL_MAX, 6'd3, 0, 0);
        add_row(REQ_SORT,    6'd0,  32'sd0,  0, ST_OK,     '0,      6'd0, 0, 0);
        add_row(REQ_READ,    6'd3,  32'sd0,  1, ST_OK,     VAL_MAX, 6'd3, 0, 0);
        add_row(REQ_REVERSE, 6'd0,  32'sd0,  0, ST_OK,     '0,      6'd0, 0, 0);
        add_row(REQ_READ,    6'd1,  32'sd0,  0, ST_OK,     '0,      6'd0, 0, 0);
        add_row(REQ_DELETE,  6'd63, 32'sd0,  1, ST_BADPOS, '0,      6'd3, 0, 0);
        add_row(REQ_DELETE,  6'd0,  32'sd0,  1, ST_BADPOS, '0,      6'd3, 0, 0);
        add_row(REQ_DELETE,  6'd2,  32'sd0,  0, ST_OK,     '0,      6'd0, 0, 0);
        add_row(REQ_APPEND,  6'd0,  32'sd0,  0, ST_OK,     '0,      6'd0, 0, 0);
        add_row(REQ_NOP6,    6'd5,  VAL_MIN, 0, ST_OK,     '0,      6'd0, 0, 0);

        // reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, back to back
        foreach (dir_rows[k]) begin
            issue_request(dir_rows[k].req, dir_rows[k].pos, dir_rows[k].val,
                          dir_rows[k].typed, dir_rows[k].res);
        end
        start <= 1'b0;

        // random passes, each under its own capacity
        for (int pass = 0; pass < NUM_PASSES; pass++) begin
            write_capacity(pass_caps[pass]);
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PASS; n++) begin
                if (burst_left == 0) begin
                    // long bursts with no idling now and then
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(40, 80);
                        gap = 0;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap = $urandom_range(0, 12);
                    end
                    if (gap != 0) begin
                        start <= 1'b0;
                        i_req_type <= REQ_W'($urandom());
                        i_position <= POS_W'($urandom());
                        i_value <= $signed($urandom());
                        repeat (gap) @(posedge i_clk);
                    end
                end
                req = pick_request(pass[0]);
                issue_request(req, pick_position(req), pick_value(), 0, no_res);
                burst_left--;
            end
            start <= 1'b0;
        end

        // drain
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
